>>> hw/rtl/hef_pkg.sv
package hef_pkg;

    localparam int MODE_W      = 3;
    localparam int LINK_W      = 10;
    localparam int NODE_W      = 16;
    localparam int EDGES_DEF   = 1024;
    localparam int WRAP_STEPS  = 8;

    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FLIP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TIP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHECK = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAN = 3'd4;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] twin;
        logic              mark;
        logic              constrained;
    } t_entry;

endpackage

>>> hw/rtl/hef_wrap.sv
module hef_wrap
    import hef_pkg::*;
#(
    parameter int EDGES = EDGES_DEF
) (
    input  logic [LINK_W-1:0] i_value,
    output logic [LINK_W-1:0] o_index
);

    logic [LINK_W-1:0] acc;

    // Restoring reduction by the table depth; a depth of four or more needs
    // no more than eight compare and subtract steps for a ten-bit link.
    always_comb begin
        acc = i_value;
        for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
            if (32'(acc) >= (32'(EDGES) << k)) begin
                acc = acc - LINK_W'(32'(EDGES) << k);
            end
        end
        o_index = acc;
    end

endmodule

>>> hw/rtl/hef_table.sv
module hef_table
    import hef_pkg::*;
#(
    parameter int EDGES = EDGES_DEF,
    parameter int AW    = $clog2(EDGES)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    output t_entry        o_rd_data
);

    t_entry r_mem [EDGES];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read issued alongside a write to the same entry returns the new word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= (i_wr_en && (i_wr_addr == i_rd_addr)) ? i_wr_data : r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

>>> hw/rtl/half_edge_flip_table_core.sv
// Half-edge table with edge flip, tip query, link check and mark cleanup.
// A command word is taken at a rising edge with start high and busy low;
// the fields i_mode, i_edge_req and the i_*_value write fields form it.
// Exactly one result word follows each command: o_tip_node and o_ok are
// valid for the single cycle in which o_valid is high. The receiver cannot
// stall; the result is taken at the edge that ends that cycle.
// Write and unknown modes answer from registers set at the accepting edge.
// Tip query, link check, mark cleanup and flip step through at most the
// states T1-T3, V1-V6, C1-C5 and F1-F11; a constrained flip stops at F1.
// busy is high from the accepting edge until the result cycle, in which a
// new command may already be taken. The length of each sequence is set by
// the table memory, which gives one read and one write a cycle, and by the
// one index wrap unit, which reduces one link a cycle. Synchronous reset
// clears the sequencer and the result strobe; the table contents are
// undefined until written.
module half_edge_flip_table_core
    import hef_pkg::*;
#(
    parameter int EDGES = EDGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [LINK_W-1:0] i_edge_req,
    input  logic [NODE_W-1:0] i_node_value,
    input  logic [LINK_W-1:0] i_next_value,
    input  logic [LINK_W-1:0] i_prev_value,
    input  logic [LINK_W-1:0] i_twin_value,
    input  logic              i_mark_value,
    input  logic              i_constrained_value,
    output logic              o_valid,
    output logic [NODE_W-1:0] o_tip_node,
    output logic              o_ok
);

    localparam int AW = $clog2(EDGES);
    localparam int XW = (AW > LINK_W) ? AW : LINK_W;
    localparam int SW = 26;

    typedef enum logic [SW-1:0] {
        ST_IDLE = 26'd1 << 0,
        ST_F1   = 26'd1 << 1,
        ST_F2   = 26'd1 << 2,
        ST_F3   = 26'd1 << 3,
        ST_F4   = 26'd1 << 4,
        ST_F5   = 26'd1 << 5,
        ST_F6   = 26'd1 << 6,
        ST_F7   = 26'd1 << 7,
        ST_F8   = 26'd1 << 8,
        ST_F9   = 26'd1 << 9,
        ST_F10  = 26'd1 << 10,
        ST_F11  = 26'd1 << 11,
        ST_T1   = 26'd1 << 12,
        ST_T2   = 26'd1 << 13,
        ST_T3   = 26'd1 << 14,
        ST_V1   = 26'd1 << 15,
        ST_V2   = 26'd1 << 16,
        ST_V3   = 26'd1 << 17,
        ST_V4   = 26'd1 << 18,
        ST_V5   = 26'd1 << 19,
        ST_V6   = 26'd1 << 20,
        ST_C1   = 26'd1 << 21,
        ST_C2   = 26'd1 << 22,
        ST_C3   = 26'd1 << 23,
        ST_C4   = 26'd1 << 24,
        ST_C5   = 26'd1 << 25
    } t_state;

    function automatic logic [AW-1:0] to_addr(input logic [LINK_W-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        return w[AW-1:0];
    endfunction

    t_state            r_state, n_state;
    logic              r_valid, n_valid;
    logic              r_ok, n_ok;
    logic [NODE_W-1:0] r_tip, n_tip;
    logic [LINK_W-1:0] r_s, n_s;
    logic [LINK_W-1:0] r_t, n_t;
    logic [LINK_W-1:0] r_n1, n_n1;
    logic [LINK_W-1:0] r_n2, n_n2;
    logic [LINK_W-1:0] r_n3, n_n3;
    logic [LINK_W-1:0] r_n4, n_n4;
    logic [LINK_W-1:0] r_tmp, n_tmp;
    logic [LINK_W-1:0] r_tmp2, n_tmp2;
    logic [NODE_W-1:0] r_node2, n_node2;
    logic [NODE_W-1:0] r_node4, n_node4;
    t_entry            r_es, n_es;

    logic [LINK_W-1:0] w_wrap_in;
    logic [LINK_W-1:0] w_wrap;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    t_entry            w_wr_data;
    t_entry            w_rd;

    hef_wrap #(
        .EDGES (EDGES)
    ) u_wrap (
        .i_value (w_wrap_in),
        .o_index (w_wrap)
    );

    hef_table #(
        .EDGES (EDGES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd)
    );

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_ok      = r_ok;
        n_tip     = r_tip;
        n_s       = r_s;
        n_t       = r_t;
        n_n1      = r_n1;
        n_n2      = r_n2;
        n_n3      = r_n3;
        n_n4      = r_n4;
        n_tmp     = r_tmp;
        n_tmp2    = r_tmp2;
        n_node2   = r_node2;
        n_node4   = r_node4;
        n_es      = r_es;
        w_wrap_in = r_es.next;
        w_rd_en   = 1'b0;
        w_rd_addr = to_addr(w_wrap);
        w_wr_en   = 1'b0;
        w_wr_addr = to_addr(r_s);
        w_wr_data = w_rd;

        case (r_state)
            ST_IDLE: begin
                w_wrap_in = i_edge_req;
                if (start) begin
                    n_s    = w_wrap;
                    n_tip  = '0;
                    case (i_mode)
                        MODE_WRITE: begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = to_addr(w_wrap);
                            w_wr_data = '{node: i_node_value, next: i_next_value,
                                          prev: i_prev_value, twin: i_twin_value,
                                          mark: i_mark_value,
                                          constrained: i_constrained_value};
                            n_valid   = 1'b1;
                            n_ok      = 1'b1;
                        end
                        MODE_FLIP: begin
                            w_rd_en = 1'b1;
                            n_state = ST_F1;
                        end
                        MODE_TIP: begin
                            w_rd_en = 1'b1;
                            n_state = ST_T1;
                        end
                        MODE_CHECK: begin
                            w_rd_en = 1'b1;
                            n_state = ST_V1;
                        end
                        MODE_CLEAN: begin
                            w_rd_en = 1'b1;
                            n_state = ST_C1;
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_ok    = 1'b0;
                        end
                    endcase
                end
            end
            ST_F1: begin
                n_es      = w_rd;
                w_wrap_in = w_rd.twin;
                if (w_rd.constrained) begin
                    w_wr_en        = 1'b1;
                    w_wr_data.mark = 1'b0;
                    n_valid        = 1'b1;
                    n_ok           = 1'b0;
                    n_state        = ST_IDLE;
                end else begin
                    n_t     = w_wrap;
                    w_rd_en = 1'b1;
                    n_state = ST_F2;
                end
            end
            ST_F2: begin
                n_tmp     = w_rd.next;
                n_tmp2    = w_rd.prev;
                w_wrap_in = r_es.prev;
                n_n2      = w_wrap;
                w_rd_en   = 1'b1;
                n_state   = ST_F3;
            end
            ST_F3: begin
                n_node2   = w_rd.node;
                w_wrap_in = r_es.next;
                n_n1      = w_wrap;
                n_state   = ST_F4;
            end
            ST_F4: begin
                w_wrap_in = r_tmp2;
                n_n4      = w_wrap;
                n_state   = ST_F5;
            end
            ST_F5: begin
                w_wrap_in = r_tmp;
                n_n3      = w_wrap;
                w_wr_en   = 1'b1;
                w_wr_data = '{node: r_node2, next: r_n4, prev: r_n1, twin: r_es.twin,
                              mark: 1'b0, constrained: r_es.constrained};
                w_rd_en   = 1'b1;
                w_rd_addr = to_addr(r_n4);
                n_state   = ST_F6;
            end
            ST_F6: begin
                n_node4   = w_rd.node;
                w_rd_en   = 1'b1;
                w_rd_addr = to_addr(r_t);
                n_state   = ST_F7;
            end
            ST_F7: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = to_addr(r_t);
                w_wr_data.node = r_node4;
                w_wr_data.next = r_n2;
                w_wr_data.prev = r_n3;
                w_wr_data.mark = 1'b0;
                w_rd_en        = 1'b1;
                w_rd_addr      = to_addr(r_n1);
                n_state        = ST_F8;
            end
            ST_F8: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = to_addr(r_n1);
                w_wr_data.next = r_s;
                w_wr_data.prev = r_n4;
                w_wr_data.mark = 1'b0;
                w_rd_en        = 1'b1;
                w_rd_addr      = to_addr(r_n2);
                n_state        = ST_F9;
            end
            ST_F9: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = to_addr(r_n2);
                w_wr_data.next = r_n3;
                w_wr_data.prev = r_t;
                w_wr_data.mark = 1'b0;
                w_rd_en        = 1'b1;
                w_rd_addr      = to_addr(r_n3);
                n_state        = ST_F10;
            end
            ST_F10: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = to_addr(r_n3);
                w_wr_data.next = r_t;
                w_wr_data.prev = r_n2;
                w_wr_data.mark = 1'b0;
                w_rd_en        = 1'b1;
                w_rd_addr      = to_addr(r_n4);
                n_state        = ST_F11;
            end
            ST_F11: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = to_addr(r_n4);
                w_wr_data.next = r_n1;
                w_wr_data.prev = r_s;
                w_wr_data.mark = 1'b0;
                n_valid        = 1'b1;
                n_ok           = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_T1: begin
                n_es      = w_rd;
                w_wrap_in = w_rd.next;
                n_n1      = w_wrap;
                w_rd_en   = 1'b1;
                n_state   = ST_T2;
            end
            ST_T2: begin
                w_wrap_in = r_es.twin;
                if (r_n1 == r_s) begin
                    w_rd_en = 1'b1;
                    n_state = ST_T3;
                end else begin
                    n_tip   = w_rd.node;
                    n_ok    = 1'b1;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_T3: begin
                n_tip   = w_rd.node;
                n_ok    = 1'b1;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_V1: begin
                n_es      = w_rd;
                w_wrap_in = w_rd.next;
                w_rd_en   = 1'b1;
                n_state   = ST_V2;
            end
            ST_V2: begin
                n_tmp     = w_rd.prev;
                w_wrap_in = r_es.prev;
                w_rd_en   = 1'b1;
                n_state   = ST_V3;
            end
            ST_V3: begin
                n_tmp2    = w_rd.next;
                w_wrap_in = r_tmp;
                n_ok      = (w_wrap == r_s);
                n_state   = ST_V4;
            end
            ST_V4: begin
                w_wrap_in = r_es.twin;
                w_rd_en   = 1'b1;
                n_state   = ST_V5;
            end
            ST_V5: begin
                w_wrap_in = r_tmp2;
                n_ok      = r_ok & (w_wrap == r_s);
                n_state   = ST_V6;
            end
            ST_V6: begin
                w_wrap_in = w_rd.twin;
                n_ok      = r_ok & (w_wrap == r_s);
                n_valid   = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_C1: begin
                n_es      = w_rd;
                w_wrap_in = w_rd.next;
                n_n1      = w_wrap;
                w_rd_en   = 1'b1;
                n_state   = ST_C2;
            end
            ST_C2: begin
                n_ok      = w_rd.mark & r_es.mark;
                w_wrap_in = r_es.prev;
                n_n2      = w_wrap;
                w_rd_en   = 1'b1;
                n_state   = ST_C3;
            end
            ST_C3: begin
                if (r_ok && w_rd.mark) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = to_addr(r_n1);
                    n_state   = ST_C4;
                end else begin
                    n_ok      = 1'b0;
                    n_valid   = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_C4: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = to_addr(r_n1);
                w_wr_data.mark = 1'b0;
                w_rd_en        = 1'b1;
                w_rd_addr      = to_addr(r_n2);
                n_state        = ST_C5;
            end
            ST_C5: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = to_addr(r_n2);
                w_wr_data.mark = 1'b0;
                n_ok           = 1'b1;
                n_valid        = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_tip   <= n_tip;
        r_s     <= n_s;
        r_t     <= n_t;
        r_n1    <= n_n1;
        r_n2    <= n_n2;
        r_n3    <= n_n3;
        r_n4    <= n_n4;
        r_tmp   <= n_tmp;
        r_tmp2  <= n_tmp2;
        r_node2 <= n_node2;
        r_node4 <= n_node4;
        r_es    <= n_es;
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_valid    = r_valid;
    assign o_ok       = r_ok;
    assign o_tip_node = r_tip;

`ifndef SYNTHESIS
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted word neither in progress nor answered");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer busy");

    a_idle_write_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && (r_state == ST_IDLE)) |-> (start && (i_mode == MODE_WRITE)))
        else $error("table written in idle without a write word");

    a_flip_reports_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F11) |=> (o_valid && o_ok && !busy))
        else $error("finished flip not reported as successful");
`endif

endmodule

>>> test/hef_flip_checker.sv
`timescale 1ns / 1ps

module hef_flip_checker
    import hef_pkg::*;
#(
    parameter int EDGES = EDGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [LINK_W-1:0] i_edge_req,
    input  logic [NODE_W-1:0] i_node_value,
    input  logic [LINK_W-1:0] i_next_value,
    input  logic [LINK_W-1:0] i_prev_value,
    input  logic [LINK_W-1:0] i_twin_value,
    input  logic              i_mark_value,
    input  logic              i_constrained_value,
    input  logic              o_valid,
    input  logic [NODE_W-1:0] o_tip_node,
    input  logic              o_ok,
    output int                o_pending,
    output int                o_fail_count,
    output int                o_checked
);

    typedef struct {
        logic [NODE_W-1:0] tip;
        logic              ok;
        logic [MODE_W-1:0] mode;
        logic [LINK_W-1:0] idx;
    } t_result_word;

    t_entry       mesh_mem [EDGES];
    t_result_word expected_q [$];
    int           pending_cnt = 0;
    int           fail_cnt    = 0;
    int           checked_cnt = 0;

    assign o_pending    = pending_cnt;
    assign o_fail_count = fail_cnt;
    assign o_checked    = checked_cnt;

    function automatic int unsigned wrap_link(input logic [LINK_W-1:0] v);
        return int'(v) % EDGES;
    endfunction

    // The table copy is updated in the same write order as the block, so
    // aliased neighbours in a degenerate mesh resolve the same way.
    function automatic t_result_word predict_word(
        input logic [MODE_W-1:0] mode,
        input logic [LINK_W-1:0] idx,
        input logic [NODE_W-1:0] node,
        input logic [LINK_W-1:0] nxt,
        input logic [LINK_W-1:0] prv,
        input logic [LINK_W-1:0] twn,
        input logic              mk,
        input logic              con
    );
        int unsigned  s, t, n1, n2, n3, n4, nx, pv, tw;
        t_result_word w;
        w.tip  = '0;
        w.ok   = 1'b0;
        w.mode = mode;
        w.idx  = idx;
        s = wrap_link(idx);
        case (mode)
            MODE_WRITE: begin
                mesh_mem[s] = '{node: node, next: nxt, prev: prv, twin: twn,
                                mark: mk, constrained: con};
                w.ok = 1'b1;
            end
            MODE_FLIP: begin
                if (mesh_mem[s].constrained) begin
                    mesh_mem[s].mark = 1'b0;
                end else begin
                    t  = wrap_link(mesh_mem[s].twin);
                    n1 = wrap_link(mesh_mem[s].next);
                    n2 = wrap_link(mesh_mem[s].prev);
                    n3 = wrap_link(mesh_mem[t].next);
                    n4 = wrap_link(mesh_mem[t].prev);

                    mesh_mem[s].node = mesh_mem[n2].node;
                    mesh_mem[s].next = LINK_W'(n4);
                    mesh_mem[s].prev = LINK_W'(n1);
                    mesh_mem[s].mark = 1'b0;

                    mesh_mem[t].node = mesh_mem[n4].node;
                    mesh_mem[t].next = LINK_W'(n2);
                    mesh_mem[t].prev = LINK_W'(n3);
                    mesh_mem[t].mark = 1'b0;

                    mesh_mem[n1].next = LINK_W'(s);
                    mesh_mem[n1].prev = LINK_W'(n4);
                    mesh_mem[n1].mark = 1'b0;

                    mesh_mem[n2].next = LINK_W'(n3);
                    mesh_mem[n2].prev = LINK_W'(t);
                    mesh_mem[n2].mark = 1'b0;

                    mesh_mem[n3].next = LINK_W'(t);
                    mesh_mem[n3].prev = LINK_W'(n2);
                    mesh_mem[n3].mark = 1'b0;

                    mesh_mem[n4].next = LINK_W'(n1);
                    mesh_mem[n4].prev = LINK_W'(s);
                    mesh_mem[n4].mark = 1'b0;
                    w.ok = 1'b1;
                end
            end
            MODE_TIP: begin
                nx = wrap_link(mesh_mem[s].next);
                tw = wrap_link(mesh_mem[s].twin);
                w.tip = (nx == s) ? mesh_mem[tw].node : mesh_mem[nx].node;
                w.ok  = 1'b1;
            end
            MODE_CHECK: begin
                nx = wrap_link(mesh_mem[s].next);
                pv = wrap_link(mesh_mem[s].prev);
                tw = wrap_link(mesh_mem[s].twin);
                w.ok = (wrap_link(mesh_mem[nx].prev) == s) &&
                       (wrap_link(mesh_mem[pv].next) == s) &&
                       (wrap_link(mesh_mem[tw].twin) == s);
            end
            MODE_CLEAN: begin
                nx = wrap_link(mesh_mem[s].next);
                pv = wrap_link(mesh_mem[s].prev);
                if (mesh_mem[s].mark && mesh_mem[nx].mark && mesh_mem[pv].mark) begin
                    mesh_mem[nx].mark = 1'b0;
                    mesh_mem[pv].mark = 1'b0;
                    w.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin : watch
        t_result_word want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "result word tip_node %h ok %b with no command outstanding",
                        o_tip_node, o_ok));
                end else begin
                    want = expected_q.pop_front();
                    checked_cnt++;
                    if (o_tip_node !== want.tip) begin
                        report_mismatch($sformatf("mode %0d edge %0d: tip_node %h, expected %h",
                                                  want.mode, want.idx, o_tip_node, want.tip));
                    end
                    if (o_ok !== want.ok) begin
                        report_mismatch($sformatf("mode %0d edge %0d: ok %b, expected %b",
                                                  want.mode, want.idx, o_ok, want.ok));
                    end
                end
            end
            if (start && !busy) begin
                expected_q.push_back(predict_word(i_mode, i_edge_req, i_node_value,
                                                  i_next_value, i_prev_value, i_twin_value,
                                                  i_mark_value, i_constrained_value));
            end
            pending_cnt = expected_q.size();
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import hef_pkg::*;

    localparam int EDGES       = EDGES_DEF;
    localparam int ITEMS       = 2000;
    localparam int QUIET_TAIL  = 200;
    localparam int PAUSE_STEP  = 500;
    localparam int STALL_LIMIT = 1000;
    localparam int MODE_TOP    = (1 << MODE_W) - 1;

    logic              i_clk               = 1'b0;
    logic              i_rst_n             = 1'b0;
    logic              start               = 1'b0;
    logic [MODE_W-1:0] i_mode              = MODE_WRITE;
    logic [LINK_W-1:0] i_edge_req          = '0;
    logic [NODE_W-1:0] i_node_value        = '0;
    logic [LINK_W-1:0] i_next_value        = '0;
    logic [LINK_W-1:0] i_prev_value        = '0;
    logic [LINK_W-1:0] i_twin_value        = '0;
    logic              i_mark_value        = 1'b0;
    logic              i_constrained_value = 1'b0;
    logic              busy;
    logic              o_valid;
    logic [NODE_W-1:0] o_tip_node;
    logic              o_ok;

    int pending;
    int fail_count;
    int checked;
    int stall_cycles = 0;
    int items        = 0;
    int pairs_built  = 0;
    int mode_count [8] = '{default: 0};
    bit idle_enable  = 1'b1;

    bit          written [EDGES];
    int unsigned written_list [$];
    int unsigned pair_ids [6];

    always #5 i_clk = ~i_clk;

    half_edge_flip_table_core #(
        .EDGES(EDGES)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_edge_req         (i_edge_req),
        .i_node_value       (i_node_value),
        .i_next_value       (i_next_value),
        .i_prev_value       (i_prev_value),
        .i_twin_value       (i_twin_value),
        .i_mark_value       (i_mark_value),
        .i_constrained_value(i_constrained_value),
        .o_valid            (o_valid),
        .o_tip_node         (o_tip_node),
        .o_ok               (o_ok)
    );

    hef_flip_checker #(
        .EDGES(EDGES)
    ) u_flip_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_edge_req         (i_edge_req),
        .i_node_value       (i_node_value),
        .i_next_value       (i_next_value),
        .i_prev_value       (i_prev_value),
        .i_twin_value       (i_twin_value),
        .i_mark_value       (i_mark_value),
        .i_constrained_value(i_constrained_value),
        .o_valid            (o_valid),
        .o_tip_node         (o_tip_node),
        .o_ok               (o_ok),
        .o_pending          (pending),
        .o_fail_count       (fail_count),
        .o_checked          (checked)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(
        input logic [MODE_W-1:0] mode,
        input int unsigned       idx,
        input logic [NODE_W-1:0] node,
        input int unsigned       nxt,
        input int unsigned       prv,
        input int unsigned       twn,
        input logic              mk,
        input logic              con
    );
        start               <= 1'b1;
        i_mode              <= mode;
        i_edge_req          <= LINK_W'(idx);
        i_node_value        <= node;
        i_next_value        <= LINK_W'(nxt);
        i_prev_value        <= LINK_W'(prv);
        i_twin_value        <= LINK_W'(twn);
        i_mark_value        <= mk;
        i_constrained_value <= con;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        mode_count[mode]++;
        if (mode <= MODE_CLEAN) begin
            items++;
        end
        if (mode == MODE_WRITE && !written[idx]) begin
            written[idx] = 1'b1;
            written_list.push_back(idx);
        end
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_op(input logic [MODE_W-1:0] mode, input int unsigned idx);
        send_word(mode, idx, NODE_W'($urandom_range(0, 65535)), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic int unsigned pick_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    function automatic int unsigned pick_link(input int unsigned s);
        if (written_list.size() == 0 || $urandom_range(0, 7) == 0) begin
            return s;
        end
        return pick_written();
    endfunction

    // Two triangles sharing the edge pair_ids[0] / pair_ids[3]; the outer
    // edges are boundary edges that are their own twins.
    task automatic build_pair(input bit plain);
        logic [NODE_W-1:0] va, vb, vc, vd;
        logic [5:0]        mk, con;
        va = NODE_W'($urandom_range(0, 65535));
        vb = NODE_W'($urandom_range(0, 65535));
        vc = NODE_W'($urandom_range(0, 65535));
        vd = NODE_W'($urandom_range(0, 65535));
        for (int k = 0; k < 6; k++) begin
            mk[k]  = plain ? 1'b1 : ($urandom_range(0, 3) != 0);
            con[k] = plain ? 1'b0 : ($urandom_range(0, 4) == 0);
        end
        send_word(MODE_WRITE, pair_ids[0], va, pair_ids[1], pair_ids[2], pair_ids[3],
                  mk[0], con[0]);
        send_word(MODE_WRITE, pair_ids[1], vb, pair_ids[2], pair_ids[0], pair_ids[1],
                  mk[1], con[1]);
        send_word(MODE_WRITE, pair_ids[2], vc, pair_ids[0], pair_ids[1], pair_ids[2],
                  mk[2], con[2]);
        send_word(MODE_WRITE, pair_ids[3], vb, pair_ids[4], pair_ids[5], pair_ids[0],
                  mk[3], con[3]);
        send_word(MODE_WRITE, pair_ids[4], va, pair_ids[5], pair_ids[3], pair_ids[4],
                  mk[4], con[4]);
        send_word(MODE_WRITE, pair_ids[5], vd, pair_ids[3], pair_ids[4], pair_ids[5],
                  mk[5], con[5]);
        pairs_built++;
    endtask

    initial begin
        int unsigned cand, target, s;
        int          roll, n_ops, next_pause, unknown_cnt;
        bit          dup;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(MODE_WRITE, 0, 16'h0000, 0, 0, 0, 1'b0, 1'b0);
        send_word(MODE_WRITE, EDGES - 1, 16'hFFFF, EDGES - 1, EDGES - 1, 0, 1'b1, 1'b1);
        send_op(MODE_TIP, 0);
        send_op(MODE_TIP, EDGES - 1);
        send_op(MODE_CHECK, 0);
        send_op(MODE_CHECK, EDGES - 1);
        send_op(MODE_FLIP, EDGES - 1);
        send_op(MODE_CLEAN, EDGES - 1);
        send_op(MODE_FLIP, 0);
        pair_ids = '{5, 6, 7, EDGES - 4, EDGES - 3, EDGES - 2};
        build_pair(1'b1);
        send_op(MODE_CHECK, pair_ids[0]);
        send_op(MODE_TIP, pair_ids[0]);
        send_op(MODE_CLEAN, pair_ids[1]);
        send_op(MODE_CLEAN, pair_ids[1]);
        send_op(MODE_FLIP, pair_ids[0]);
        send_op(MODE_CHECK, pair_ids[3]);
        send_op(MODE_TIP, pair_ids[0]);
        send_word(MODE_WRITE, 512, 16'hFFFF, EDGES - 1, 0, EDGES - 1, 1'b1, 1'b0);
        send_op(MODE_CLEAN, 512);
        for (int m = MODE_CLEAN + 1; m <= MODE_TOP; m++) begin
            send_op(MODE_W'(m), EDGES - 1);
        end
        drain();

        next_pause = PAUSE_STEP;
        while (items < ITEMS) begin
            idle_enable = (items < ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 55) begin
                for (int k = 0; k < 6; k++) begin
                    do begin
                        cand = $urandom_range(0, EDGES - 1);
                        dup  = 1'b0;
                        for (int j = 0; j < k; j++) begin
                            if (pair_ids[j] == cand) begin
                                dup = 1'b1;
                            end
                        end
                    end while (dup);
                    pair_ids[k] = cand;
                end
                build_pair(1'b0);
                n_ops = $urandom_range(3, 8);
                for (int k = 0; k < n_ops; k++) begin
                    roll   = $urandom_range(0, 99);
                    target = pair_ids[$urandom_range(0, 5)];
                    if (roll < 35) begin
                        if ($urandom_range(0, 2) != 0) begin
                            target = pair_ids[$urandom_range(0, 1) * 3];
                        end
                        send_op(MODE_FLIP, target);
                    end else if (roll < 55) begin
                        send_op(MODE_TIP, target);
                    end else if (roll < 80) begin
                        send_op(MODE_CHECK, target);
                    end else begin
                        send_op(MODE_CLEAN, target);
                    end
                end
            end else begin
                n_ops = $urandom_range(1, 6);
                for (int k = 0; k < n_ops; k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 30) begin
                        s = $urandom_range(0, EDGES - 1);
                        send_word(MODE_WRITE, s, NODE_W'($urandom_range(0, 65535)),
                                  pick_link(s), pick_link(s), pick_link(s),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end else if (roll < 90) begin
                        send_op(MODE_W'($urandom_range(MODE_FLIP, MODE_CLEAN)), pick_written());
                    end else begin
                        send_op(MODE_W'($urandom_range(MODE_CLEAN + 1, MODE_TOP)),
                                $urandom_range(0, EDGES - 1));
                    end
                end
            end
            if (items >= next_pause) begin
                drain();
                next_pause += PAUSE_STEP;
            end
        end

        drain();
        repeat (16) @(posedge i_clk);

        unknown_cnt = mode_count[5] + mode_count[6] + mode_count[7];
        $display(
            "%0d commands: %0d write, %0d flip, %0d tip, %0d check, %0d cleanup, %0d unknown.",
            items + unknown_cnt,
            mode_count[MODE_WRITE], mode_count[MODE_FLIP], mode_count[MODE_TIP],
            mode_count[MODE_CHECK], mode_count[MODE_CLEAN], unknown_cnt);
        $display("%0d two-triangle meshes were built and %0d result words were checked.",
                 pairs_built, checked);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
